FILE: rtl/core/ludd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ludd_pkg: shared types and constants for the LU decomposition block
// Holds the sequencer state type, the status codes and fixed field widths.
// ----------------------------------------------------------------------------
package ludd_pkg;

	localparam int unsigned DataW = 32;
	localparam int unsigned IdxW  = 3;
	localparam int unsigned CfgW  = 4;

	// result status codes
	localparam logic STAT_OK         = 1'b0;
	localparam logic STAT_ZERO_PIVOT = 1'b1;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_PIV_RD,
		ST_PIV_CHK,
		ST_ELEM_LD,
		ST_A_RD,
		ST_B_RD,
		ST_MUL,
		ST_SUB,
		ST_SUM,
		ST_DIV,
		ST_WR,
		ST_DET_RD,
		ST_DET_MUL,
		ST_DET_SAT,
		ST_OUT_RD,
		ST_OUT_EMIT,
		ST_FAIL
	} state_t;

endpackage
`default_nettype wire

FILE: rtl/core/ludd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ludd_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module ludd_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write or read one word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire

FILE: rtl/core/lu_decompose_determinant_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lu_decompose_determinant_top: Doolittle LU factoring with determinant
// Loads an n-by-n Q matrix, factors it in place with one shared multiplier and a
// bit-serial divider, then emits every factor entry and the determinant, or a zero-pivot failure.
// ----------------------------------------------------------------------------
// Sequence: one element per cycle while start is high in the load state; then each U
//   entry reads its element and subtracts its k products, each L entry also checks
//   its pivot and divides (32+FRAC_BITS divide steps), the determinant multiplies in
//   each diagonal entry, and each result is read from the RAM and emitted.
// Throughput: one matrix at a time; busy is high from the last element until
//   the final result. Reset clears all registers except size_q (to 4) and det_q (to one), but not the matrix RAM.
module lu_decompose_determinant_top #(
	parameter int unsigned MAX_DIM   = 8,
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] element_value,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [3:0]  cfg_data,
	output logic             strobe,
	output logic [2:0]       entry_row,
	output logic [2:0]       entry_col,
	output logic [31:0]      entry_value,
	output logic [31:0]      determinant,
	output logic             status,
	output logic             last_entry
);

	localparam int unsigned Depth = MAX_DIM * MAX_DIM;
	localparam int unsigned AW    = $clog2(Depth);
	localparam int unsigned DW    = $clog2(MAX_DIM + 1);
	localparam int unsigned IW    = $clog2(MAX_DIM);
	localparam int unsigned CntW  = $clog2(Depth + 1);
	localparam int unsigned DivW  = 32 + FRAC_BITS;
	localparam int unsigned QCntW = $clog2(DivW + 1);
	localparam logic signed [31:0] QOne = 32'sd1 <<< FRAC_BITS;
	localparam logic signed [63:0] SMax = 64'sd2147483647;
	localparam logic signed [63:0] SMin = -64'sd2147483648;

	ludd_pkg::state_t state_q, state_d;

	logic [3:0]        size_q;
	logic [DW-1:0]     n_q;
	logic [CntW-1:0]   load_q;
	logic [IW-1:0]     i_q, j_q, p_q;
	logic signed [63:0] acc_q;
	logic signed [31:0] opa_q, piv_q, det_q;
	logic signed [63:0] prod_q;
	// divider registers
	logic [DivW-1:0]   dnum_q, dquo_q;
	logic [31:0]       dden_q;
	logic [31:0]       drem_q;
	logic [QCntW-1:0]  dcnt_q;
	logic              dneg_q;

	// RAM port
	logic              ram_we;
	logic [AW-1:0]     ram_addr;
	logic [31:0]       ram_wdata, ram_rdata;

	ludd_ram #(.WIDTH(32), .DEPTH(Depth)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// effective dimension
	logic [DW-1:0] n_now;
	always_comb begin
		if (size_q == 4'd0) begin
			n_now = DW'(1);
		end else if (32'(size_q) > MAX_DIM) begin
			n_now = DW'(MAX_DIM);
		end else begin
			n_now = DW'(size_q);
		end
	end

	function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] r, input logic [IW-1:0] c,
		input logic [DW-1:0] n);
		logic [15:0] t;
		t = 16'(r) * 16'(n) + 16'(c);
		return t[AW-1:0];
	endfunction

	function automatic logic signed [31:0] sat(input logic signed [63:0] v);
		if (v > SMax) return 32'sh7fffffff;
		if (v < SMin) return 32'sh80000000;
		return v[31:0];
	endfunction

	// truncating Q shift of a product: bias negatives before the shift
	function automatic logic signed [63:0] qshift(input logic signed [63:0] v);
		logic signed [63:0] b;
		b = v[63] ? ((64'sd1 <<< FRAC_BITS) - 64'sd1) : 64'sd0;
		return (v + b) >>> FRAC_BITS;
	endfunction

	logic [CntW-1:0]    nn;
	logic               in_xfer, j_lt_i;
	logic [IW-1:0]      n_last, kmax;
	logic signed [31:0] sum32, term, mul_a;
	logic signed [63:0] mul_p, quo_s;
	logic [31:0]        sum_mag, piv_mag;
	logic [32:0]        div_r;
	logic               div_ge;
	assign nn        = CntW'(n_now) * CntW'(n_now);
	assign in_xfer   = start && !busy;
	assign j_lt_i    = j_q < i_q;
	assign n_last    = IW'(n_q - DW'(1));
	assign kmax      = j_lt_i ? j_q : i_q;
	assign sum32     = sat(acc_q);
	assign term      = sat(qshift(prod_q));
	assign cfg_ready = !busy;

	// shared multiplier: elimination products or the determinant
	assign mul_a = (state_q == ludd_pkg::ST_DET_MUL) ? det_q : opa_q;
	assign mul_p = mul_a * $signed(ram_rdata);

	// divider operands and one restoring step
	assign sum_mag = sum32[31] ? 32'(-sum32) : 32'(sum32);
	assign piv_mag = piv_q[31] ? 32'(-piv_q) : 32'(piv_q);
	assign div_r   = {drem_q, dnum_q[DivW-1]};
	assign div_ge  = div_r >= {1'b0, dden_q};
	assign quo_s   = dneg_q ? -$signed(64'(dquo_q)) : $signed(64'(dquo_q));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ludd_pkg::ST_LOAD: begin
				if (in_xfer && (load_q + CntW'(1) >= nn)) state_d = ludd_pkg::ST_PIV_RD;
			end
			ludd_pkg::ST_PIV_RD: state_d = j_lt_i ? ludd_pkg::ST_PIV_CHK : ludd_pkg::ST_ELEM_LD;
			ludd_pkg::ST_PIV_CHK: begin
				state_d = (ram_rdata == 32'd0) ? ludd_pkg::ST_FAIL : ludd_pkg::ST_ELEM_LD;
			end
			ludd_pkg::ST_ELEM_LD: begin
				if (kmax == '0) state_d = j_lt_i ? ludd_pkg::ST_SUM : ludd_pkg::ST_WR;
				else state_d = ludd_pkg::ST_A_RD;
			end
			ludd_pkg::ST_A_RD: state_d = ludd_pkg::ST_B_RD;
			ludd_pkg::ST_B_RD: state_d = ludd_pkg::ST_MUL;
			ludd_pkg::ST_MUL: state_d = ludd_pkg::ST_SUB;
			ludd_pkg::ST_SUB: begin
				if (p_q == kmax) state_d = j_lt_i ? ludd_pkg::ST_SUM : ludd_pkg::ST_WR;
				else state_d = ludd_pkg::ST_A_RD;
			end
			ludd_pkg::ST_SUM: state_d = ludd_pkg::ST_DIV;
			ludd_pkg::ST_DIV: if (dcnt_q == QCntW'(1)) state_d = ludd_pkg::ST_WR;
			ludd_pkg::ST_WR: begin
				if (i_q == n_last && j_q == n_last) state_d = ludd_pkg::ST_DET_RD;
				else state_d = ludd_pkg::ST_PIV_RD;
			end
			ludd_pkg::ST_DET_RD: state_d = ludd_pkg::ST_DET_MUL;
			ludd_pkg::ST_DET_MUL: state_d = ludd_pkg::ST_DET_SAT;
			ludd_pkg::ST_DET_SAT: begin
				state_d = (i_q == n_last) ? ludd_pkg::ST_OUT_RD : ludd_pkg::ST_DET_RD;
			end
			ludd_pkg::ST_OUT_RD: state_d = ludd_pkg::ST_OUT_EMIT;
			ludd_pkg::ST_OUT_EMIT: begin
				if (i_q == n_last && j_q == n_last) state_d = ludd_pkg::ST_LOAD;
				else state_d = ludd_pkg::ST_OUT_RD;
			end
			ludd_pkg::ST_FAIL: state_d = ludd_pkg::ST_LOAD;
			default: state_d = ludd_pkg::ST_LOAD;
		endcase
	end

	// outputs and RAM control
	always_comb begin
		busy      = (state_q != ludd_pkg::ST_LOAD);
		ram_we    = 1'b0;
		ram_addr  = addr_of(i_q, j_q, n_q);
		ram_wdata = element_value;
		case (state_q)
			ludd_pkg::ST_LOAD: begin
				ram_we   = in_xfer && (load_q < CntW'(Depth));
				ram_addr = load_q[AW-1:0];
			end
			ludd_pkg::ST_PIV_RD: begin
				ram_addr = j_lt_i ? addr_of(j_q, j_q, n_q) : addr_of(i_q, j_q, n_q);
			end
			ludd_pkg::ST_A_RD: ram_addr = addr_of(i_q, p_q, n_q);
			ludd_pkg::ST_B_RD: ram_addr = addr_of(p_q, j_q, n_q);
			ludd_pkg::ST_WR: begin
				ram_we    = 1'b1;
				ram_wdata = j_lt_i ? sat(quo_s) : sum32;
			end
			ludd_pkg::ST_DET_RD: ram_addr = addr_of(i_q, i_q, n_q);
			default: ;
		endcase
	end

	// datapath: one multiplier, one serial divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ludd_pkg::ST_LOAD;
			size_q      <= 4'd4;
			n_q         <= '0;
			load_q      <= '0;
			i_q         <= '0;
			j_q         <= '0;
			p_q         <= '0;
			acc_q       <= '0;
			opa_q       <= '0;
			piv_q       <= '0;
			det_q       <= QOne;
			prod_q      <= '0;
			dnum_q      <= '0;
			dquo_q      <= '0;
			dden_q      <= '0;
			drem_q      <= '0;
			dcnt_q      <= '0;
			dneg_q      <= 1'b0;
			strobe      <= 1'b0;
			entry_row   <= '0;
			entry_col   <= '0;
			entry_value <= '0;
			determinant <= '0;
			status      <= ludd_pkg::STAT_OK;
			last_entry  <= 1'b0;
		end else begin
			state_q <= state_d;
			strobe  <= (state_q == ludd_pkg::ST_OUT_EMIT) || (state_q == ludd_pkg::ST_FAIL);
			if (cfg_valid && cfg_ready) size_q <= cfg_data;
			case (state_q)
				ludd_pkg::ST_LOAD: begin
					if (in_xfer) begin
						if (load_q + CntW'(1) >= nn) begin
							load_q <= '0;
							n_q    <= n_now;
							i_q    <= '0;
							j_q    <= '0;
							det_q  <= QOne;
						end else begin
							load_q <= load_q + CntW'(1);
						end
					end
				end
				ludd_pkg::ST_PIV_CHK: piv_q <= ram_rdata;
				ludd_pkg::ST_ELEM_LD: begin
					acc_q <= 64'($signed(ram_rdata));
					p_q   <= '0;
				end
				ludd_pkg::ST_B_RD: opa_q <= ram_rdata;
				ludd_pkg::ST_MUL: begin
					prod_q <= mul_p;
					p_q    <= p_q + IW'(1);
				end
				ludd_pkg::ST_SUB: acc_q <= acc_q - 64'(term);
				ludd_pkg::ST_SUM: begin
					dneg_q <= sum32[31] ^ piv_q[31];
					dnum_q <= {sum_mag, {FRAC_BITS{1'b0}}};
					dden_q <= piv_mag;
					drem_q <= '0;
					dcnt_q <= QCntW'(DivW);
				end
				ludd_pkg::ST_DIV: begin
					dnum_q <= dnum_q << 1;
					dquo_q <= {dquo_q[DivW-2:0], div_ge};
					drem_q <= div_ge ? 32'(div_r - {1'b0, dden_q}) : div_r[31:0];
					dcnt_q <= dcnt_q - QCntW'(1);
				end
				ludd_pkg::ST_WR: begin
					if (j_q == n_last) begin
						j_q <= '0;
						i_q <= (i_q == n_last) ? '0 : i_q + IW'(1);
					end else begin
						j_q <= j_q + IW'(1);
					end
				end
				ludd_pkg::ST_DET_MUL: prod_q <= mul_p;
				ludd_pkg::ST_DET_SAT: begin
					det_q <= term;
					i_q   <= (i_q == n_last) ? '0 : i_q + IW'(1);
				end
				ludd_pkg::ST_OUT_EMIT: begin
					entry_row   <= 3'(i_q);
					entry_col   <= 3'(j_q);
					entry_value <= ram_rdata;
					determinant <= det_q;
					status      <= ludd_pkg::STAT_OK;
					last_entry  <= (i_q == n_last) && (j_q == n_last);
					if (j_q == n_last) begin
						j_q <= '0;
						i_q <= (i_q == n_last) ? '0 : i_q + IW'(1);
					end else begin
						j_q <= j_q + IW'(1);
					end
				end
				ludd_pkg::ST_FAIL: begin
					entry_row   <= 3'(j_q);
					entry_col   <= 3'(j_q);
					entry_value <= '0;
					determinant <= '0;
					status      <= ludd_pkg::STAT_ZERO_PIVOT;
					last_entry  <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// a strobe follows only an emit or fail state
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ($past(state_q) == ludd_pkg::ST_OUT_EMIT || $past(state_q) == ludd_pkg::ST_FAIL))
		else $error("strobe without emit");
	// failure results are always last
	assert property (@(posedge clk) disable iff (!arst_n) (strobe && status) |-> last_entry)
		else $error("fail not last");
	// a final result returns the block to loading
	assert property (@(posedge clk) disable iff (!arst_n) (strobe && last_entry) |-> !busy)
		else $error("not idle after last");
	// the divider never runs on a zero pivot
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ludd_pkg::ST_DIV) |-> (dden_q != '0))
		else $error("divide by zero");

endmodule
`default_nettype wire
